>>> rtl/nws_pkg.sv
// Shared types and constants for the nearest waypoint search block.
package nws_pkg;

  localparam int INDEX_W    = 10;
  localparam int SPEED_W    = 16;
  localparam int PATH_LEN_W = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_PATH_LENGTH    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HORIZON_POINTS = 1'b1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [PATH_LEN_W-1:0] PATH_LEN_RESET = 11'd1;
  localparam logic [INDEX_W-1:0]    HORIZON_RESET  = 10'd30;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_en;     // write the requested waypoint into the table
    logic start;     // clear the scan counter, capture the vehicle position
    logic rd_en;     // read the entry under the scan counter and advance
    logic load_out;  // move the winner into the output registers
  } nws_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic at_last;    // scan counter sits on the last valid entry
    logic scan_done;  // last entry has passed the compare stage
  } nws_sts_t;

endpackage

>>> rtl/nws_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nws_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/nws_ctrl.sv
// Controller state machine: sequences loads, scans and result hand-off.
module nws_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              opcode_i,
  input  logic              out_stall_i,
  input  nws_pkg::nws_sts_t sts_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  output nws_pkg::nws_cmd_t cmd_o
);
  import nws_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e   state_q;
  logic     out_valid_q;
  logic     accept;
  nws_cmd_t cmd;

  always_comb begin
    accept       = in_valid_i && (state_q == ST_IDLE);
    cmd          = '0;
    cmd.wr_en    = accept && (opcode_i == OP_LOAD);
    cmd.start    = accept && (opcode_i == OP_QUERY);
    cmd.rd_en    = (state_q == ST_SCAN);
    cmd.load_out = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd.start) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (sts_i.at_last) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (sts_i.scan_done) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (cmd.load_out) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // hold the result until the far side takes it
      if (cmd.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign cmd_o       = cmd;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> !(out_valid_q && out_stall_i))
    else $error("pending result overwritten");

  a_start_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |=> (state_q == ST_SCAN))
    else $error("query did not start a scan");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && sts_i.at_last) |=> (state_q == ST_DRAIN))
    else $error("scan overran the last entry");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_FINISH))
    else $error("result raised outside the finish step");

endmodule

>>> rtl/nws_datapath.sv
// Datapath: waypoint table, scan counter, distance pipeline and best tracker.
module nws_datapath #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [nws_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [nws_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  nws_pkg::nws_cmd_t                cmd_i,
  output nws_pkg::nws_sts_t                sts_o,
  input  logic [nws_pkg::INDEX_W-1:0]      entry_index_i,
  input  logic [COORD_BITS-1:0]            point_x_i,
  input  logic [COORD_BITS-1:0]            point_y_i,
  input  logic [nws_pkg::SPEED_W-1:0]      point_speed_i,
  input  logic [COORD_BITS-1:0]            car_x_i,
  input  logic [COORD_BITS-1:0]            car_y_i,
  output logic [nws_pkg::INDEX_W-1:0]      closest_index_o,
  output logic [nws_pkg::INDEX_W-1:0]      window_last_index_o,
  output logic [nws_pkg::SPEED_W-1:0]      desired_speed_o
);
  import nws_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int RW = 2 * C + SPEED_W;
  localparam int H  = (C + 1) / 2;           // low half of a magnitude
  localparam int HI = C - H;                 // high half of a magnitude
  localparam int DW = 2 * C + 1;             // sum of two squares
  localparam int EW = ((INDEX_W > AW) ? INDEX_W : AW) + 1;
  localparam int LW = ((AW + 1) > PATH_LEN_W) ? (AW + 1) : PATH_LEN_W;
  localparam int SW = ((AW > INDEX_W) ? AW : INDEX_W) + 1;

  // configuration
  logic [PATH_LEN_W-1:0] path_length_q;
  logic [INDEX_W-1:0]    horizon_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_length_q <= PATH_LEN_RESET;
      horizon_q     <= HORIZON_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PATH_LENGTH:    path_length_q <= cfg_data_i[PATH_LEN_W-1:0];
        REG_HORIZON_POINTS: horizon_q     <= cfg_data_i[INDEX_W-1:0];
        default: ;
      endcase
    end
  end

  // zero length counts as one, lengths beyond the table saturate
  logic [LW-1:0] len_raw, len_eff;
  logic [AW-1:0] tail_idx;

  always_comb begin
    len_raw = LW'(path_length_q);
    if (len_raw == '0) begin
      len_eff = LW'(1);
    end else if (len_raw > LW'(MAX_POINTS)) begin
      len_eff = LW'(MAX_POINTS);
    end else begin
      len_eff = len_raw;
    end
    tail_idx = AW'(len_eff - LW'(1));
  end

  // table
  logic          wr_ok;
  logic [AW-1:0] cnt_q;
  logic [RW-1:0] rdata;

  assign wr_ok = EW'(entry_index_i) < EW'(MAX_POINTS);

  nws_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en && wr_ok),
    .waddr_i (AW'(entry_index_i)),
    .wdata_i ({point_speed_i, point_y_i, point_x_i}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cnt_q),
    .rdata_o (rdata)
  );

  // scan counter and vehicle position
  logic [C-1:0] car_x_q, car_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.start) begin
      cnt_q <= '0;
    end else if (cmd_i.rd_en) begin
      cnt_q <= cnt_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      car_x_q <= car_x_i;
      car_y_q <= car_y_i;
    end
  end

  // pipeline tags: valid, last, index
  logic [4:1]    v_q;
  logic [4:0]    l_q;
  logic          v0_q;
  logic [AW-1:0] i0_q, i1_q, i2_q, i3_q, i4_q;
  logic          done_q;

  // stage 1: absolute differences
  logic [1:0][C-1:0] wp;
  logic [1:0][C-1:0] car;
  logic [1:0][C:0]   diff;
  logic [1:0][C-1:0] mag;

  always_comb begin
    wp[0]  = rdata[C-1:0];
    wp[1]  = rdata[2*C-1:C];
    car[0] = car_x_q;
    car[1] = car_y_q;
    for (int k = 0; k < 2; k++) begin
      diff[k] = {wp[k][C-1], wp[k]} - {car[k][C-1], car[k]};
      mag[k]  = diff[k][C] ? C'(-diff[k]) : C'(diff[k]);
    end
  end

  logic [1:0][C-1:0]      mag1_q;
  logic [SPEED_W-1:0]     spd1_q, spd2_q, spd3_q, spd4_q;
  logic [1:0][2*H-1:0]    ll2_q;
  logic [1:0][C-1:0]      lh2_q;
  logic [1:0][2*HI-1:0]   hh2_q;
  logic [1:0][2*C-1:0]    sq3_q;
  logic [DW-1:0]          dist4_q;

  // stage 2 operands: halves of each magnitude
  logic [1:0][H-1:0]  lo;
  logic [1:0][HI-1:0] hi;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      lo[k] = mag1_q[k][H-1:0];
      hi[k] = mag1_q[k][C-1:H];
    end
  end

  always_ff @(posedge clk_i) begin
    // stage 1
    mag1_q <= mag;
    spd1_q <= rdata[2*C +: SPEED_W];
    // stage 2: partial products
    for (int k = 0; k < 2; k++) begin
      ll2_q[k] <= (2*H)'(lo[k]) * (2*H)'(lo[k]);
      lh2_q[k] <= C'(lo[k]) * C'(hi[k]);
      hh2_q[k] <= (2*HI)'(hi[k]) * (2*HI)'(hi[k]);
    end
    spd2_q <= spd1_q;
    // stage 3: assemble squares
    for (int k = 0; k < 2; k++) begin
      sq3_q[k] <= ((2*C)'(hh2_q[k]) << (2 * H))
                + ((2*C)'(lh2_q[k]) << (H + 1))
                + (2*C)'(ll2_q[k]);
    end
    spd3_q <= spd2_q;
    // stage 4: squared distance
    dist4_q <= DW'(sq3_q[0]) + DW'(sq3_q[1]);
    spd4_q  <= spd3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v_q    <= '0;
      l_q    <= '0;
      done_q <= 1'b0;
    end else begin
      v0_q   <= cmd_i.rd_en;
      l_q[0] <= cmd_i.rd_en && sts_o.at_last;
      v_q    <= {v_q[3:1], v0_q};
      l_q[4:1] <= l_q[3:0];
      done_q <= v_q[4] && l_q[4];
    end
  end

  always_ff @(posedge clk_i) begin
    i0_q <= cnt_q;
    i1_q <= i0_q;
    i2_q <= i1_q;
    i3_q <= i2_q;
    i4_q <= i3_q;
  end

  // stage 5: keep the strictly smaller distance, first entry always taken
  logic [DW-1:0]      best_d_q;
  logic [AW-1:0]      best_idx_q;
  logic [SPEED_W-1:0] best_spd_q;

  always_ff @(posedge clk_i) begin
    if (v_q[4] && ((i4_q == '0) || (dist4_q < best_d_q))) begin
      best_d_q   <= dist4_q;
      best_idx_q <= i4_q;
      best_spd_q <= spd4_q;
    end
  end

  // horizon window end
  logic [SW-1:0] win_sum, win_end;

  always_comb begin
    win_sum = SW'(best_idx_q) + SW'(horizon_q);
    win_end = (win_sum > SW'(tail_idx)) ? SW'(tail_idx) : win_sum;
  end

  logic [INDEX_W-1:0] closest_q, window_q;
  logic [SPEED_W-1:0] speed_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      closest_q <= INDEX_W'(best_idx_q);
      window_q  <= INDEX_W'(win_end);
      speed_q   <= best_spd_q;
    end
  end

  assign sts_o.at_last   = (cnt_q == tail_idx);
  assign sts_o.scan_done = done_q;

  assign closest_index_o     = closest_q;
  assign window_last_index_o = window_q;
  assign desired_speed_o     = speed_q;

endmodule

>>> rtl/nearest_waypoint_search_top.sv
// Top level of the nearest waypoint search block.
// Nearest waypoint search over a table of MAX_POINTS waypoints (x, y and speed).
// A load request writes one waypoint and gives no result; a load to an index
// outside the table is dropped. A query request scans entries 0 to path_length-1
// through one table read port, one entry per cycle, and pushes each through a
// squared-distance pipeline. Ties go to the lowest index. One request is worked
// on at a time, but a finished result waits in the output register while the
// next request is taken. Entries must be loaded before a query reads them. Write
// configuration only while the block is idle.
module nearest_waypoint_search_top #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [nws_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [nws_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           opcode_i,
  input  logic [nws_pkg::INDEX_W-1:0]    entry_index_i,
  input  logic [COORD_BITS-1:0]          point_x_i,
  input  logic [COORD_BITS-1:0]          point_y_i,
  input  logic [nws_pkg::SPEED_W-1:0]    point_speed_i,
  input  logic [COORD_BITS-1:0]          car_x_i,
  input  logic [COORD_BITS-1:0]          car_y_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [nws_pkg::INDEX_W-1:0]    closest_index_o,
  output logic [nws_pkg::INDEX_W-1:0]    window_last_index_o,
  output logic [nws_pkg::SPEED_W-1:0]    desired_speed_o
);
  import nws_pkg::*;

  nws_cmd_t cmd;
  nws_sts_t sts;

  assign cfg_ready_o = 1'b1;

  nws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .opcode_i    (opcode_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  nws_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_valid_i && cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .entry_index_i       (entry_index_i),
    .point_x_i           (point_x_i),
    .point_y_i           (point_y_i),
    .point_speed_i       (point_speed_i),
    .car_x_i             (car_x_i),
    .car_y_i             (car_y_i),
    .closest_index_o     (closest_index_o),
    .window_last_index_o (window_last_index_o),
    .desired_speed_o     (desired_speed_o)
  );

endmodule
